>>> hdl/sjm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial joystick to motor PWM: shared package
// Widths, character codes, thresholds, reciprocal constants and the structs
// passed between the parser, the arithmetic units and the result pipeline.
// ----------------------------------------------------------------------------
package sjm_pkg;

  localparam int LINE_BYTES_DEF = 100;

  localparam int RX_W       = 8;
  localparam int JOY_W      = 12;
  localparam int DUTY_W     = 16;
  localparam int DTOP_W     = 16;
  localparam int STOP_W     = 24;
  localparam int SERVO_W    = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int OUT_FIELDS_W = 2 * JOY_W + 2 * DUTY_W + 2 + SERVO_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_TOP = 1'b0,
    CFG_SERVO_TOP = 1'b1
  } cfg_idx_t;

  localparam logic [DTOP_W-1:0] DRIVE_TOP_RST = 16'd4199;
  localparam logic [STOP_W-1:0] SERVO_TOP_RST = 24'd1679999;

  localparam logic [RX_W-1:0] RX_NEWLINE = 8'h0A;
  localparam logic [RX_W-1:0] RX_NUL     = 8'h00;
  localparam logic [RX_W-1:0] RX_COMMA   = 8'h2C;
  localparam logic [RX_W-1:0] RX_ZERO    = 8'h30;
  localparam logic [RX_W-1:0] RX_NINE    = 8'h39;

  localparam logic [JOY_W-1:0] JOY_MIN    = 12'd10;
  localparam logic [JOY_W-1:0] JOY_MAX    = 12'd3890;
  localparam logic [JOY_W-1:0] JOY_HI_THR = 12'd2020;
  localparam logic [JOY_W-1:0] JOY_LO_THR = 12'd1900;
  localparam logic [JOY_W-1:0] JOY_CENTER = 12'd2000;

  // Axis duty: distance from center times top, divided by 2096 or 2000.
  // Both divisors are 16 times a small odd number, so the low four bits are
  // dropped first and the rest is a reciprocal multiply with one correction.
  localparam int AX_DIFF_W    = 11;
  localparam int AX_N_W       = AX_DIFF_W + DTOP_W;
  localparam int AX_PRE_SHIFT = 4;
  localparam int AX_M_W       = AX_N_W - AX_PRE_SHIFT;
  localparam int AX_REC_W     = 17;
  localparam int AX_P_W       = AX_M_W + AX_REC_W;
  localparam int AX_DIV_W     = 8;
  localparam int AX_REC_SHIFT = 23;
  localparam logic [AX_DIV_W-1:0] AX_DIV_HI = 8'd131;
  localparam logic [AX_DIV_W-1:0] AX_DIV_LO = 8'd125;
  localparam logic [AX_REC_W-1:0] AX_REC_HI = 17'd64035;
  localparam logic [AX_REC_W-1:0] AX_REC_LO = 17'd67108;

  // Servo: servo_top / 10 and / 20 through a reciprocal of five, then the
  // span times y divided by 4095 through a shift-add reciprocal.
  localparam int SV_A_W      = STOP_W - 1;
  localparam int SV_REC_W    = 21;
  localparam int SV_PA_W     = SV_A_W + SV_REC_W;
  localparam int SV_REC_SHIFT = 23;
  localparam int SV_Q5_W     = 21;
  localparam int SV_SPAN_W   = 20;
  localparam int SV_P_W      = JOY_W + SV_SPAN_W;
  localparam int SV_SUM_W    = 2 * SV_P_W + 1;
  localparam int SV_REC2_SHIFT = 44;
  localparam int SV_Q_W      = 20;
  localparam logic [SV_REC_W-1:0] SV_REC5   = 21'd1677721;
  localparam logic [SV_A_W-1:0]   SV_DIV5   = 23'd5;
  localparam logic [SV_P_W-1:0]   SV_DIV4095 = 32'd4095;

  typedef struct packed {
    logic [JOY_W-1:0] joy_x;
    logic [JOY_W-1:0] joy_y;
    logic             drive_forward;
    logic             turn_left;
  } line_t;

  typedef struct packed {
    logic b;
    logic c;
    logic d;
    logic e;
    logic f;
  } pipe_en_t;

endpackage

>>> hdl/sjm_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial joystick line parser
// Accumulates the decimal x and y fields of each line and, on newline,
// presents the clamped values and the updated direction pins in a register.
// ----------------------------------------------------------------------------
module sjm_line_parser #(
  parameter int LINE_BYTES = sjm_pkg::LINE_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [sjm_pkg::RX_W-1:0] rx_byte,
  output logic                     line_valid,
  input  logic                     line_ready,
  output sjm_pkg::line_t           line
);
  import sjm_pkg::*;

  localparam int CNT_W = $clog2(LINE_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_BYTES - 1);

  logic [JOY_W-1:0] x_acc_r, x_acc_nxt;
  logic [JOY_W-1:0] y_acc_r, y_acc_nxt;
  logic             second_r, second_nxt;
  logic             term_r, term_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             dpin_r, dpin_nxt;
  logic             tpin_r, tpin_nxt;
  logic             line_v_r, line_v_nxt;
  line_t            line_r;

  logic             fire;
  logic             is_nl;
  logic             is_digit;
  logic [3:0]       digit_full;
  logic [JOY_W-1:0] acc_sel;
  logic [JOY_W-1:0] acc_mac;
  logic [JOY_W-1:0] x_clamp;
  logic [JOY_W-1:0] y_clamp;
  logic             dpin_new;
  logic             tpin_new;

  function automatic logic [JOY_W-1:0] clamp_joy(input logic [JOY_W-1:0] v);
    logic [JOY_W-1:0] r;
    r = v;
    if (r > JOY_MAX) r = JOY_MAX;
    if (r < JOY_MIN) r = JOY_MIN;
    return r;
  endfunction

  assign in_ready   = !line_v_r || line_ready;
  assign fire       = in_valid && in_ready;
  assign is_nl      = (rx_byte == RX_NEWLINE);
  assign is_digit   = (rx_byte >= RX_ZERO) && (rx_byte <= RX_NINE);
  assign digit_full = 4'(rx_byte - RX_ZERO);
  assign acc_sel    = second_r ? y_acc_r : x_acc_r;
  assign acc_mac    = {acc_sel[JOY_W-4:0], 3'b000} + {acc_sel[JOY_W-2:0], 1'b0}
                    + {{(JOY_W-4){1'b0}}, digit_full};
  assign x_clamp    = clamp_joy(x_acc_r);
  assign y_clamp    = clamp_joy(y_acc_r);

  always_comb begin
    dpin_new = dpin_r;
    if (y_clamp > JOY_HI_THR) dpin_new = 1'b1;
    else if (y_clamp < JOY_LO_THR) dpin_new = 1'b0;
    tpin_new = tpin_r;
    if (x_clamp > JOY_HI_THR) tpin_new = 1'b0;
    else if (x_clamp < JOY_LO_THR) tpin_new = 1'b1;
  end

  always_comb begin
    x_acc_nxt  = x_acc_r;
    y_acc_nxt  = y_acc_r;
    second_nxt = second_r;
    term_nxt   = term_r;
    cnt_nxt    = cnt_r;
    dpin_nxt   = dpin_r;
    tpin_nxt   = tpin_r;
    if (fire) begin
      if (is_nl) begin
        x_acc_nxt  = '0;
        y_acc_nxt  = '0;
        second_nxt = 1'b0;
        term_nxt   = 1'b0;
        cnt_nxt    = '0;
        dpin_nxt   = dpin_new;
        tpin_nxt   = tpin_new;
      end else if (cnt_r < CNT_LAST) begin
        cnt_nxt = cnt_r + 1'b1;
        if (!term_r) begin
          if (rx_byte == RX_NUL) begin
            term_nxt = 1'b1;
          end else if ((rx_byte == RX_COMMA) && !second_r) begin
            second_nxt = 1'b1;
          end else if (is_digit) begin
            if (second_r) y_acc_nxt = acc_mac;
            else x_acc_nxt = acc_mac;
          end
        end
      end
    end
    line_v_nxt = in_ready ? (fire && is_nl) : line_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r  <= '0;
      y_acc_r  <= '0;
      second_r <= 1'b0;
      term_r   <= 1'b0;
      cnt_r    <= '0;
      dpin_r   <= 1'b0;
      tpin_r   <= 1'b0;
      line_v_r <= 1'b0;
    end else begin
      x_acc_r  <= x_acc_nxt;
      y_acc_r  <= y_acc_nxt;
      second_r <= second_nxt;
      term_r   <= term_nxt;
      cnt_r    <= cnt_nxt;
      dpin_r   <= dpin_nxt;
      tpin_r   <= tpin_nxt;
      line_v_r <= line_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_nl) begin
      line_r.joy_x         <= x_clamp;
      line_r.joy_y         <= y_clamp;
      line_r.drive_forward <= dpin_new;
      line_r.turn_left     <= tpin_new;
    end
  end

  assign line_valid = line_v_r;
  assign line       = line_r;

endmodule

>>> hdl/sjm_axis_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis duty unit
// Three-stage datapath giving the motor compare value for one joystick axis:
// product with the period count, reciprocal multiply, then a remainder fix.
// ----------------------------------------------------------------------------
module sjm_axis_duty (
  input  logic                         clk,
  input  sjm_pkg::pipe_en_t            en,
  input  logic [sjm_pkg::JOY_W-1:0]    joy,
  input  logic [sjm_pkg::DTOP_W-1:0]   top,
  output logic [sjm_pkg::DUTY_W-1:0]   duty
);
  import sjm_pkg::*;

  logic                 above;
  logic                 below;
  logic [JOY_W-1:0]     delta;
  logic [AX_DIFF_W-1:0] diff;

  logic [AX_N_W-1:0]    n_r;
  logic                 sel_b_r;
  logic [AX_M_W-1:0]    m;
  logic [AX_REC_W-1:0]  rec;
  logic [AX_P_W-1:0]    p_r;
  logic [AX_M_W-1:0]    m_c_r;
  logic                 sel_c_r;
  logic [DUTY_W-1:0]    q_est;
  logic [AX_DIV_W-1:0]  dv;
  logic [AX_M_W-1:0]    q_prod;
  logic [AX_M_W-1:0]    rem;
  logic [DUTY_W-1:0]    duty_r;

  assign above = (joy > JOY_HI_THR);
  assign below = (joy < JOY_LO_THR);

  always_comb begin
    delta = '0;
    if (above) delta = joy - JOY_CENTER;
    else if (below) delta = JOY_CENTER - joy;
  end

  assign diff = delta[AX_DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (en.b) begin
      n_r     <= {{DTOP_W{1'b0}}, diff} * {{AX_DIFF_W{1'b0}}, top};
      sel_b_r <= above;
    end
  end

  assign m   = n_r[AX_N_W-1:AX_PRE_SHIFT];
  assign rec = sel_b_r ? AX_REC_HI : AX_REC_LO;

  always_ff @(posedge clk) begin
    if (en.c) begin
      p_r     <= {{AX_REC_W{1'b0}}, m} * {{AX_M_W{1'b0}}, rec};
      m_c_r   <= m;
      sel_c_r <= sel_b_r;
    end
  end

  assign q_est  = p_r[AX_REC_SHIFT +: DUTY_W];
  assign dv     = sel_c_r ? AX_DIV_HI : AX_DIV_LO;
  assign q_prod = {{(AX_M_W-DUTY_W){1'b0}}, q_est} * {{(AX_M_W-AX_DIV_W){1'b0}}, dv};
  assign rem    = m_c_r - q_prod;

  always_ff @(posedge clk) begin
    if (en.d) begin
      duty_r <= q_est + DUTY_W'(rem >= {{(AX_M_W-AX_DIV_W){1'b0}}, dv});
    end
  end

  assign duty = duty_r;

endmodule

>>> hdl/sjm_servo_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo duty unit
// Five-stage datapath: pulse bounds from the servo period, span times the
// vertical value, division by 4095 and the final offset.
// ----------------------------------------------------------------------------
module sjm_servo_duty (
  input  logic                         clk,
  input  sjm_pkg::pipe_en_t            en,
  input  logic [sjm_pkg::JOY_W-1:0]    joy_y,
  input  logic [sjm_pkg::STOP_W-1:0]   top,
  output logic [sjm_pkg::SERVO_W-1:0]  servo
);
  import sjm_pkg::*;

  logic [SV_A_W-1:0]    a;
  logic [SV_A_W-1:0]    b;
  logic [SV_PA_W-1:0]   pa_r;
  logic [SV_PA_W-1:0]   pb_r;
  logic [SV_A_W-1:0]    a_b_r;
  logic [SV_A_W-1:0]    b_b_r;
  logic [JOY_W-1:0]     y_b_r;

  logic [SV_Q5_W-1:0]   qa;
  logic [SV_Q5_W-1:0]   qb;
  logic [SV_A_W-1:0]    ra;
  logic [SV_A_W-1:0]    rb;
  logic [SV_Q5_W-1:0]   hi;
  logic [SV_Q5_W-1:0]   lo;
  logic [SV_Q5_W-1:0]   span;
  logic [SV_SPAN_W-1:0] span_c_r;
  logic [SV_SPAN_W-1:0] lo_c_r;
  logic [JOY_W-1:0]     y_c_r;

  logic [SV_P_W-1:0]    p_d_r;
  logic [SV_SPAN_W-1:0] lo_d_r;

  logic [SV_SUM_W-1:0]  rsum;
  logic [SV_Q_W-1:0]    q_e_r;
  logic [SV_P_W-1:0]    p_e_r;
  logic [SV_SPAN_W-1:0] lo_e_r;

  logic [SV_P_W-1:0]    q_prod;
  logic [SV_P_W-1:0]    rem;
  logic [SV_Q_W-1:0]    q_fix;
  logic [SERVO_W-1:0]   servo_r;

  assign a = top[STOP_W-1:1];
  assign b = {1'b0, top[STOP_W-1:2]};

  always_ff @(posedge clk) begin
    if (en.b) begin
      pa_r  <= {{SV_REC_W{1'b0}}, a} * {{SV_A_W{1'b0}}, SV_REC5};
      pb_r  <= {{SV_REC_W{1'b0}}, b} * {{SV_A_W{1'b0}}, SV_REC5};
      a_b_r <= a;
      b_b_r <= b;
      y_b_r <= joy_y;
    end
  end

  assign qa   = pa_r[SV_REC_SHIFT +: SV_Q5_W];
  assign qb   = pb_r[SV_REC_SHIFT +: SV_Q5_W];
  assign ra   = a_b_r - ({qa, 2'b00} + {2'b00, qa});
  assign rb   = b_b_r - ({qb, 2'b00} + {2'b00, qb});
  assign hi   = qa + SV_Q5_W'(ra >= SV_DIV5);
  assign lo   = qb + SV_Q5_W'(rb >= SV_DIV5);
  assign span = hi - lo;

  always_ff @(posedge clk) begin
    if (en.c) begin
      span_c_r <= span[SV_SPAN_W-1:0];
      lo_c_r   <= lo[SV_SPAN_W-1:0];
      y_c_r    <= y_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.d) begin
      p_d_r  <= {{SV_SPAN_W{1'b0}}, y_c_r} * {{JOY_W{1'b0}}, span_c_r};
      lo_d_r <= lo_c_r;
    end
  end

  // The reciprocal of 4095 scaled by 2^44 is 2^32 + 2^20 + 2^8.
  assign rsum = {1'b0, p_d_r, 32'd0}
              + {13'd0, p_d_r, 20'd0}
              + {25'd0, p_d_r, 8'd0};

  always_ff @(posedge clk) begin
    if (en.e) begin
      q_e_r  <= rsum[SV_REC2_SHIFT +: SV_Q_W];
      p_e_r  <= p_d_r;
      lo_e_r <= lo_d_r;
    end
  end

  assign q_prod = {q_e_r, 12'd0} - {12'd0, q_e_r};
  assign rem    = p_e_r - q_prod;
  assign q_fix  = q_e_r + SV_Q_W'(rem >= SV_DIV4095);

  always_ff @(posedge clk) begin
    if (en.f) begin
      servo_r <= {{(SERVO_W-SV_Q_W){1'b0}}, q_fix}
               + {{(SERVO_W-SV_SPAN_W){1'b0}}, lo_e_r};
    end
  end

  assign servo = servo_r;

endmodule

>>> hdl/sjm_duty_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result pipeline
// Five registered stages with per-stage valid bits that close up bubbles; the
// last stage is the output register of the result channel.
// ----------------------------------------------------------------------------
module sjm_duty_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            line_valid,
  output logic                            line_ready,
  input  sjm_pkg::line_t                  line,
  input  logic [sjm_pkg::DTOP_W-1:0]      drive_top,
  input  logic [sjm_pkg::STOP_W-1:0]      servo_top,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sjm_pkg::OUT_DATA_W-1:0]  out_data
);
  import sjm_pkg::*;

  localparam int NSTAGE = 5;

  logic [NSTAGE-1:0] v_r, v_nxt;
  logic [NSTAGE-1:0] rdy;
  pipe_en_t          en;
  line_t             ln_r [NSTAGE];

  logic [DUTY_W-1:0]  drive_d;
  logic [DUTY_W-1:0]  turn_d;
  logic [DUTY_W-1:0]  drive_e_r, drive_f_r;
  logic [DUTY_W-1:0]  turn_e_r, turn_f_r;
  logic [SERVO_W-1:0] servo_f;

  always_comb begin
    rdy[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? line_valid : v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign en.b = rdy[0];
  assign en.c = rdy[1];
  assign en.d = rdy[2];
  assign en.e = rdy[3];
  assign en.f = rdy[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) ln_r[0] <= line;
  end

  for (genvar g = 1; g < NSTAGE; g++) begin : g_line
    always_ff @(posedge clk) begin
      if (rdy[g]) ln_r[g] <= ln_r[g-1];
    end
  end

  sjm_axis_duty u_drive (
    .clk  (clk),
    .en   (en),
    .joy  (line.joy_y),
    .top  (drive_top),
    .duty (drive_d)
  );

  sjm_axis_duty u_turn (
    .clk  (clk),
    .en   (en),
    .joy  (line.joy_x),
    .top  (drive_top),
    .duty (turn_d)
  );

  sjm_servo_duty u_servo (
    .clk   (clk),
    .en    (en),
    .joy_y (line.joy_y),
    .top   (servo_top),
    .servo (servo_f)
  );

  always_ff @(posedge clk) begin
    if (en.e) begin
      drive_e_r <= drive_d;
      turn_e_r  <= turn_d;
    end
    if (en.f) begin
      drive_f_r <= drive_e_r;
      turn_f_r  <= turn_e_r;
    end
  end

  assign line_ready = rdy[0];
  assign out_valid  = v_r[NSTAGE-1];
  assign out_data   = {{OUT_PAD_W{1'b0}}, servo_f,
                       ln_r[NSTAGE-1].turn_left, turn_f_r,
                       ln_r[NSTAGE-1].drive_forward, drive_f_r,
                       ln_r[NSTAGE-1].joy_y, ln_r[NSTAGE-1].joy_x};

endmodule

>>> hdl/serial_joystick_to_motor_pwm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial joystick to motor PWM unit
// Parses "x,y" text lines from a serial byte stream and, per line, produces
// clamped joystick values, drive and turn motor compare values with their
// direction pins, and a servo compare value.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, and back-to-back bytes never stall while
// the output side keeps up. Each newline produces one result transaction: the
// edge that accepts it loads the parser's line register, and the pipeline
// stages then carry the line through the arithmetic pipeline, whose depth is
// set by the reciprocal-multiply divisions. Up to six results can be in
// flight; only when all of them wait on out_tready does in_tready drop. Bytes
// other than newline produce no result. Configuration writes take effect at
// once and must only be made while no result is pending.
// ----------------------------------------------------------------------------
module serial_joystick_to_motor_pwm_unit #(
  parameter int LINE_BYTES = sjm_pkg::LINE_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // rx_byte[7:0]
  input  logic [sjm_pkg::RX_W-1:0]           in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // joy_x[11:0], joy_y[23:12], drive_duty[39:24], drive_forward[40],
  // turn_duty[56:41], turn_left[57], servo_duty[81:58], zero pad[87:82]
  output logic [sjm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [sjm_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [sjm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sjm_pkg::*;

  logic [DTOP_W-1:0] drive_top_r, drive_top_nxt;
  logic [STOP_W-1:0] servo_top_r, servo_top_nxt;
  logic              line_valid;
  logic              line_ready;
  line_t             line;

  always_comb begin
    drive_top_nxt = drive_top_r;
    servo_top_nxt = servo_top_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_DRIVE_TOP: drive_top_nxt = cfg_wdata[DTOP_W-1:0];
        CFG_SERVO_TOP: servo_top_nxt = cfg_wdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_top_r <= DRIVE_TOP_RST;
      servo_top_r <= SERVO_TOP_RST;
    end else begin
      drive_top_r <= drive_top_nxt;
      servo_top_r <= servo_top_nxt;
    end
  end

  sjm_line_parser #(
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .rx_byte    (in_tdata),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line       (line)
  );

  sjm_duty_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line       (line),
    .drive_top  (drive_top_r),
    .servo_top  (servo_top_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

>>> hdl/sjm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial joystick to motor PWM: port checker
// Watches the result channel of the top level and checks value ranges,
// the deadband rule and the transaction handshake.
// ----------------------------------------------------------------------------
module sjm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sjm_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import sjm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:0] >= JOY_MIN) && (out_tdata[11:0] <= JOY_MAX))
    else $error("joy_x outside clamp range");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:12] >= JOY_MIN) && (out_tdata[23:12] <= JOY_MAX))
    else $error("joy_y outside clamp range");

  a_deadband: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:12] >= JOY_LO_THR) && (out_tdata[23:12] <= JOY_HI_THR)
    |-> (out_tdata[39:24] == '0))
    else $error("drive duty not zero in deadband");

endmodule

bind serial_joystick_to_motor_pwm_unit sjm_checker u_sjm_checker (.*);
